// ===== rtl/sufs_pkg.sv =====
// Shared types, constants and the Q1.23 coefficient table for the stereo upmix block.
package sufs_pkg;

	// Sample and field widths
	localparam int SAMPLE_W   = 32;
	localparam int COEF_W     = 24;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = 64;
	localparam int GAIN_W     = 15;
	localparam int MODE_W     = 2;
	localparam int COEF_IDX_W = 6;
	localparam int COEF_COUNT = 31;
	localparam int FRAC_SHIFT = 23;

	// Configuration register indexes
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_MODE   = 2'd1;
	localparam logic [1:0] CFG_GAIN   = 2'd2;

	// Output modes; the unused code behaves like MODE_3_2_1
	localparam logic [MODE_W-1:0] MODE_2_0_0 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_2_2_0 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_3_2_1 = 2'd2;

	// Register reset values
	localparam logic              ENABLE_RST = 1'b1;
	localparam logic [MODE_W-1:0] MODE_RST   = MODE_3_2_1;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 15'd20675;

	// Center and LFE clamp, about +-0.999999
	localparam logic signed [SAMPLE_W:0] CLAMP_HI = 33'sd2147481500;
	localparam logic signed [SAMPLE_W:0] CLAMP_LO = -33'sd2147481500;

	// Surround FIR coefficients, Q1.23
	localparam logic signed [COEF_W-1:0] COEF_Q23 [COEF_COUNT] = '{
		-24'sd78055, -24'sd79191, -24'sd80279, -24'sd81313, -24'sd82290, -24'sd83205,
		-24'sd84055, -24'sd84834, -24'sd85539, -24'sd86165, -24'sd86708, -24'sd87162,
		-24'sd87524, -24'sd87787, -24'sd87949, 24'sd8223129, -24'sd87949, -24'sd87787,
		-24'sd87524, -24'sd87162, -24'sd86708, -24'sd86165, -24'sd85539, -24'sd84834,
		-24'sd84055, -24'sd83205, -24'sd82290, -24'sd81313, -24'sd80279, -24'sd79191,
		-24'sd78055
	};

	// Top-level sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LAUNCH,
		ST_FIR,
		ST_EMIT
	} state_t;

	// Status a FIR lane reports back to the sequencer
	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] y;
	} lane_stat_t;

	// Coefficient lookup; taps past the table use zero
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (idx < COEF_IDX_W'(COEF_COUNT)) begin
			c = COEF_Q23[idx[4:0]];
		end
		return c;
	endfunction

endpackage

// ===== rtl/sufs_lane.sv =====
// One surround FIR lane: circular history memory and a pipelined multiply-accumulate.
module sufs_lane #(
	parameter int TAPS = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [sufs_pkg::SAMPLE_W-1:0] x,
	output sufs_pkg::lane_stat_t                 stat
);

	localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;

	// History memory plus one valid bit per entry (unwritten entries read as zero)
	logic [sufs_pkg::SAMPLE_W-1:0] mem [TAPS];
	logic [TAPS-1:0]               valid_q;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] rd_addr_q;
	logic [TW-1:0] tap_q;
	logic          issue_q;

	logic                                 rd_v_s1;
	logic                                 last_s1;
	logic                                 hit_s1;
	logic [sufs_pkg::SAMPLE_W-1:0]        rdata_s1;
	logic signed [sufs_pkg::COEF_W-1:0]   coef_s1;
	logic signed [sufs_pkg::SAMPLE_W-1:0] data_s1;

	logic                               mul_v_s2;
	logic                               last_s2;
	logic signed [sufs_pkg::PROD_W-1:0] prod_s2;

	logic signed [sufs_pkg::ACC_W-1:0]    acc_q;
	logic                                 fin_q;
	logic                                 done_q;
	logic signed [sufs_pkg::SAMPLE_W-1:0] y_q;

	localparam int SH_W = sufs_pkg::ACC_W - sufs_pkg::FRAC_SHIFT;
	logic signed [SH_W-1:0]               sh;
	logic signed [sufs_pkg::SAMPLE_W-1:0] sat;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		logic [AW-1:0] n;
		n = (a == AW'(TAPS - 1)) ? '0 : a + 1'b1;
		return n;
	endfunction

	// History write and registered read
	always_ff @(posedge clk) begin
		if (start) begin
			mem[ptr_q] <= x;
		end
		if (issue_q) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (start) begin
			valid_q[ptr_q] <= 1'b1;
		end
	end

	// Tap sequencer: walks from the oldest entry to the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_addr_q <= '0;
			tap_q     <= '0;
			issue_q   <= 1'b0;
		end else if (start) begin
			ptr_q     <= wrap_inc(ptr_q);
			rd_addr_q <= wrap_inc(ptr_q);
			tap_q     <= TW'(TAPS - 1);
			issue_q   <= 1'b1;
		end else if (issue_q) begin
			rd_addr_q <= wrap_inc(rd_addr_q);
			tap_q     <= tap_q - 1'b1;
			if (tap_q == '0) begin
				issue_q <= 1'b0;
			end
		end
	end

	// Stage 1: read data, valid bit and coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue_q;
			last_s1 <= issue_q && (tap_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (issue_q) begin
			hit_s1  <= valid_q[rd_addr_q];
			coef_s1 <= sufs_pkg::coef_at(sufs_pkg::COEF_IDX_W'(tap_q));
		end
	end

	assign data_s1 = hit_s1 ? $signed(rdata_s1) : '0;

	// Stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			mul_v_s2 <= rd_v_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_s2 <= data_s1 * coef_s1;
		end
	end

	// Accumulate, then scale and saturate once the last tap is in
	assign sh = acc_q[sufs_pkg::ACC_W-1:sufs_pkg::FRAC_SHIFT];

	always_comb begin
		if (sh > SH_W'(32'sh7fff_ffff)) begin
			sat = 32'sh7fff_ffff;
		end else if (sh < -SH_W'(33'sh0_8000_0000)) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = sh[sufs_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			y_q    <= '0;
		end else begin
			fin_q <= mul_v_s2 && last_s2;
			if (start) begin
				acc_q  <= '0;
				done_q <= 1'b0;
			end else if (mul_v_s2) begin
				acc_q <= acc_q + prod_s2;
			end
			if (fin_q) begin
				y_q    <= sat;
				done_q <= 1'b1;
			end
		end
	end

	assign stat.done = done_q;
	assign stat.y    = y_q;

endmodule

// ===== rtl/sufs_merge.sv =====
// Merging stage: combines gained channels and lane results, holds the output register.
module sufs_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic                                   enable,
	input  logic [sufs_pkg::MODE_W-1:0]            mode,
	input  logic signed [sufs_pkg::SAMPLE_W-1:0]   gl,
	input  logic signed [sufs_pkg::SAMPLE_W-1:0]   gr,
	input  sufs_pkg::lane_stat_t                   lane_l,
	input  sufs_pkg::lane_stat_t                   lane_r,
	output logic                                   room,
	output logic                                   tvalid,
	input  logic                                   tready,
	output logic [6*sufs_pkg::SAMPLE_W-1:0]        tdata
);

	logic fir_en;
	logic full;

	logic signed [sufs_pkg::SAMPLE_W-1:0] ls;
	logic signed [sufs_pkg::SAMPLE_W-1:0] rs;
	logic signed [sufs_pkg::SAMPLE_W:0]   c_sum;
	logic signed [sufs_pkg::SAMPLE_W:0]   lfe_sum;
	logic signed [sufs_pkg::SAMPLE_W-1:0] center;
	logic signed [sufs_pkg::SAMPLE_W-1:0] lfe;

	logic                                 tvalid_q;
	logic [6*sufs_pkg::SAMPLE_W-1:0]      tdata_q;

	function automatic logic signed [sufs_pkg::SAMPLE_W-1:0] clamp(
		input logic signed [sufs_pkg::SAMPLE_W:0] v
	);
		logic signed [sufs_pkg::SAMPLE_W:0] r;
		r = v;
		if (v > sufs_pkg::CLAMP_HI) begin
			r = sufs_pkg::CLAMP_HI;
		end else if (v < sufs_pkg::CLAMP_LO) begin
			r = sufs_pkg::CLAMP_LO;
		end
		return r[sufs_pkg::SAMPLE_W-1:0];
	endfunction

	// Mode decode: FIR outputs in 2_2_0 and up, center and LFE only in 3_2_1 and the unused code
	assign fir_en = enable && (mode != sufs_pkg::MODE_2_0_0);
	assign full   = enable && (mode != sufs_pkg::MODE_2_0_0) && (mode != sufs_pkg::MODE_2_2_0);

	assign ls      = fir_en ? lane_l.y : '0;
	assign rs      = fir_en ? lane_r.y : '0;
	assign c_sum   = (sufs_pkg::SAMPLE_W+1)'(gl) + (sufs_pkg::SAMPLE_W+1)'(gr);
	assign lfe_sum = (sufs_pkg::SAMPLE_W+1)'(ls) + (sufs_pkg::SAMPLE_W+1)'(rs);
	assign center  = full ? clamp(c_sum) : '0;
	assign lfe     = full ? clamp(lfe_sum) : '0;

	// Output register
	assign room = !tvalid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (load) begin
			tvalid_q <= 1'b1;
		end else if (tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= {lfe, rs, gr, center, gl, ls};
		end
	end

	assign tvalid = tvalid_q;
	assign tdata  = tdata_q;

endmodule

// ===== rtl/stereo_upmix_fir_surround.sv =====
// Top level of the stereo-to-surround upmixer: sequencer, gain stage, two FIR lanes, merge.
// One stereo frame at a time. In modes 2_2_0 and 3_2_1 the time from acceptance to result is
// set by the two FIR lanes, each stepping one tap per cycle through its history memory and a
// single multiply-accumulate, both lanes in lockstep; in mode 2_0_0 or when disabled the
// lanes are skipped. A result waits in ST_EMIT until the output register has room. The next
// frame is accepted in the cycle after the result is loaded, while the previous result
// still waits on the output.
// Histories reset to zero at once; there is no clearing pass.
module stereo_upmix_fir_surround #(
	parameter int TAPS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	// input frames
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // [31:0] left_sample, [63:32] right_sample
	// output frames
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // ls_out, left_out, center_out, right_out, rs_out,
	                                    // lfe_out, 32 bits each from bit 0 up
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data
);

	sufs_pkg::state_t state_q, state_d;

	logic                                 enable_q;
	logic [sufs_pkg::MODE_W-1:0]          mode_q;
	logic [sufs_pkg::GAIN_W-1:0]          gain_q;

	logic signed [sufs_pkg::SAMPLE_W-1:0] l_q;
	logic signed [sufs_pkg::SAMPLE_W-1:0] r_q;
	logic signed [sufs_pkg::SAMPLE_W-1:0] gl_q;
	logic signed [sufs_pkg::SAMPLE_W-1:0] gr_q;
	logic signed [47:0]                   gl_prod;
	logic signed [47:0]                   gr_prod;

	logic                 in_acc;
	logic                 fir_en;
	logic                 lane_start;
	logic                 merge_load;
	logic                 merge_room;
	sufs_pkg::lane_stat_t lane_l;
	sufs_pkg::lane_stat_t lane_r;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign fir_en    = enable_q && (mode_q != sufs_pkg::MODE_2_0_0);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= sufs_pkg::ENABLE_RST;
			mode_q   <= sufs_pkg::MODE_RST;
			gain_q   <= sufs_pkg::GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sufs_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				sufs_pkg::CFG_MODE:   mode_q   <= cfg_data[sufs_pkg::MODE_W-1:0];
				sufs_pkg::CFG_GAIN:   gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input capture and gain (Q1.31 times unsigned Q0.15, floor shift by 15)
	assign gl_prod = l_q * $signed({1'b0, gain_q});
	assign gr_prod = r_q * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		if (in_acc) begin
			l_q <= s_axis_tdata[31:0];
			r_q <= s_axis_tdata[63:32];
		end
		if (state_q == sufs_pkg::ST_MUL) begin
			gl_q <= enable_q ? gl_prod[46:15] : l_q;
			gr_q <= enable_q ? gr_prod[46:15] : r_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sufs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		lane_start    = 1'b0;
		merge_load    = 1'b0;
		unique case (state_q)
			sufs_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = sufs_pkg::ST_MUL;
				end
			end
			sufs_pkg::ST_MUL: begin
				state_d = sufs_pkg::ST_LAUNCH;
			end
			sufs_pkg::ST_LAUNCH: begin
				if (fir_en) begin
					lane_start = 1'b1;
					state_d    = sufs_pkg::ST_FIR;
				end else begin
					state_d = sufs_pkg::ST_EMIT;
				end
			end
			sufs_pkg::ST_FIR: begin
				if (lane_l.done && lane_r.done) begin
					state_d = sufs_pkg::ST_EMIT;
				end
			end
			sufs_pkg::ST_EMIT: begin
				if (merge_room) begin
					merge_load = 1'b1;
					state_d    = sufs_pkg::ST_IDLE;
				end
			end
			default: state_d = sufs_pkg::ST_IDLE;
		endcase
	end

	// Left and right surround lanes
	sufs_lane #(.TAPS(TAPS)) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.x      (gl_q),
		.stat   (lane_l)
	);

	sufs_lane #(.TAPS(TAPS)) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.x      (gr_q),
		.stat   (lane_r)
	);

	sufs_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (merge_load),
		.enable (enable_q),
		.mode   (mode_q),
		.gl     (gl_q),
		.gr     (gr_q),
		.lane_l (lane_l),
		.lane_r (lane_r),
		.room   (merge_room),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata)
	);

	// Both lanes run in lockstep and finish together
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_l.done == lane_r.done)
		else $error("FIR lanes out of step");

	// Lanes start only for a mode that uses the FIR
	a_start_mode: assert property (@(posedge clk) disable iff (!arst_n)
		lane_start |-> fir_en)
		else $error("FIR lane started in a mode without surround");

	// An accepted frame moves straight to the gain stage
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == sufs_pkg::ST_MUL)
		else $error("accepted frame not taken to gain stage");

	// A result is loaded only when the output register has room
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		merge_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

endmodule
